/* hw/rtl/bcba_pkg.sv */
// ----------------------------------------------------------------------------
// bcba_pkg
// Shared types and constants of the contiguous block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bcba_pkg;

  // Map geometry
  localparam int unsigned NUM_BLOCKS_DEF = 32768;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned BA_W           = 17;  // wide enough for a block address plus a run length

  // Register reset values and counter limit
  localparam logic [15:0] DATA_START_RST = 16'd138;
  localparam logic [15:0] BLOCKS_RST     = 16'd32768;
  localparam logic [15:0] CNT_MAX        = 16'hFFFF;

  // Register indexes
  localparam logic CFG_DATA_START = 1'b0;
  localparam logic CFG_BLOCKS     = 1'b1;

  // Request kinds
  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_FREE   = 2'd1;
  localparam logic [1:0] FUNC_FORMAT = 2'd2;

  // Result codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;

  // Outcome of one searched map word
  typedef struct packed {
    logic            hit;
    logic [BA_W-1:0] start;
    logic [BA_W-1:0] carry;
  } scan_res_t;

endpackage

`default_nettype wire

/* hw/rtl/bcba_if.sv */
// ----------------------------------------------------------------------------
// bcba_if
// Request and response channels of the contiguous block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] run_length;
  logic [14:0] first_block;

  modport source (output valid, output func, output run_length, output first_block,
                  input ready);
  modport sink   (input valid, input func, input run_length, input first_block,
                  output ready);
endinterface

interface bcba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [14:0] alloc_start;
  logic [15:0] free_count;

  modport source (output valid, output status, output alloc_start, output free_count,
                  input ready);
  modport sink   (input valid, input status, input alloc_start, input free_count,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/bcba_map_ram.sv */
// ----------------------------------------------------------------------------
// bcba_map_ram
// Used-map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bcba_map_ram import bcba_pkg::*; #(
  parameter int unsigned DEPTH = NUM_BLOCKS_DEF / WORD_BITS,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WORD_BITS-1:0] wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bcba_word_scan.sv */
// ----------------------------------------------------------------------------
// bcba_word_scan
// First-fit search step over one 64-block map word with a carried run length.
// ----------------------------------------------------------------------------
`default_nettype none

module bcba_word_scan import bcba_pkg::*; (
  input  wire logic [WORD_BITS-1:0] free_i,   // 1 = free and inside the search range
  input  wire logic [BA_W-1:0]      base_i,   // block number of bit 0
  input  wire logic [BA_W-1:0]      carry_i,  // free run ending just below bit 0
  input  wire logic [15:0]          len_i,
  output scan_res_t                 res_o
);

  localparam logic [BA_W-1:0] CARRY_MAX = '1;

  always_comb begin
    logic [WORD_BITS-1:0] p [7];
    logic [WORD_BITS-1:0] acc;
    logic                 first;
    logic [6:0]           pre;
    logic [6:0]           lead;
    logic [5:0]           pb;
    logic                 hit_b;
    logic [BA_W:0]        sum_a;
    logic [BA_W:0]        sum_c;

    // Free bits from bit 0 up and from bit 63 down
    pre = 7'd64;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!free_i[i]) pre = 7'(i);
    end
    lead = 7'd64;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!free_i[i]) lead = 7'(WORD_BITS - 1 - i);
    end

    // Runs of 2^k free blocks ending at each bit
    p[0] = free_i;
    for (int k = 1; k < 7; k++) begin
      p[k] = p[k-1] & (p[k-1] << (1 << (k - 1)));
    end

    // Combine the powers of two that make up the length
    acc   = '1;
    first = 1'b1;
    for (int k = 0; k < 7; k++) begin
      if (len_i[k]) begin
        acc   = first ? p[k] : (p[k] & (acc << (1 << k)));
        first = 1'b0;
      end
    end
    hit_b = (len_i <= 16'd64) && (acc != '0);

    pb = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (acc[i]) pb = 6'(i);
    end

    // A run entering from below ends earliest, so it wins
    sum_a = {1'b0, carry_i} + (BA_W+1)'(pre);
    res_o.hit   = (sum_a >= (BA_W+1)'(len_i)) || hit_b;
    if (sum_a >= (BA_W+1)'(len_i)) begin
      res_o.start = base_i - carry_i;
    end else begin
      res_o.start = base_i + BA_W'(pb) + BA_W'(1) - BA_W'(len_i);
    end

    // Carry the run that reaches the top bit
    sum_c = {1'b0, carry_i} + (BA_W+1)'(WORD_BITS);
    if (pre == 7'd64) begin
      res_o.carry = sum_c[BA_W] ? CARRY_MAX : sum_c[BA_W-1:0];
    end else begin
      res_o.carry = BA_W'(lead);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bitmap_contiguous_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator
// First-fit contiguous block allocator over a one-bit-per-block used map.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (allocate, free, format) and each gives one
// response on rsp_o with a status, the start of an allocated run and the
// free-block counter. The map lives in a RAM of 64-bit words (NUM_BLOCKS/64
// words, 512 by default); every operation that touches the map walks it one word per cycle.
// Format: one write per word over the whole map.
// Free: read-modify-write over the words of the run.
// Allocate: the search reads one word per cycle from the end of the reserved
// area to the volume end and stops at the first fit, then the run is marked
// in a second pass.
// Rejected requests answer without touching the map.
// After reset the map RAM is cleared in a pass over all NUM_BLOCKS/64 words
// (512 by default) during which no request is taken; configuration writes
// are taken at all times. The counter reads zero until the first format or free.
// The response sits in an output register; a new request is taken while it
// waits, and a finished result waits until the receiver takes the old one.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_contiguous_block_allocator import bcba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  bcba_req_if.sink         req_i,
  bcba_rsp_if.source       rsp_o
);

  localparam int unsigned NUM_WORDS = NUM_BLOCKS / WORD_BITS;
  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned XW = (AW + 1 > 11) ? AW + 1 : 11;
  localparam logic [XW-1:0] LAST_WORD = XW'(NUM_WORDS - 1);

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_SCAN, ST_RMW, ST_DONE
  } state_e;

  // Bits of word w that lie in [lo, hi)
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [XW-1:0]   w,
                                                     input logic [BA_W-1:0] lo,
                                                     input logic [BA_W-1:0] hi);
    logic [XW-1:0]        lw;
    logic [XW-1:0]        hw;
    logic [WORD_BITS-1:0] ge;
    logic [WORD_BITS-1:0] lt;
    lw = XW'(lo >> 6);
    hw = XW'(hi >> 6);
    ge = (w > lw) ? '1 : ((w == lw) ? ({WORD_BITS{1'b1}} << lo[5:0]) : '0);
    lt = (w < hw) ? '1 : ((w == hw) ? ~({WORD_BITS{1'b1}} << hi[5:0]) : '0);
    return ge & lt;
  endfunction

  state_e          state_q,  state_d;
  logic [15:0]     dstart_q, blocks_q;
  logic [15:0]     cnt_q,    cnt_d;
  logic [XW-1:0]   w_q,      w_d;
  logic [XW-1:0]   pw_q,     pw_d;
  logic            pv_q,     pv_d;
  logic [BA_W-1:0] lo_q,     lo_d;
  logic [BA_W-1:0] hi_q,     hi_d;
  logic [BA_W-1:0] carry_q,  carry_d;
  logic            set_q,    set_d;
  logic            clr_q,    clr_d;
  logic [15:0]     len_q,    len_d;
  logic [1:0]      stat_q,   stat_d;
  logic [BA_W-1:0] start_q,  start_d;
  logic            ov_q,     ov_d;
  logic [1:0]      ostat_q,  ostat_d;
  logic [14:0]     ostart_q, ostart_d;
  logic [15:0]     ocnt_q,   ocnt_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic [BA_W-1:0]      tot, ds, fend;
  logic [XW-1:0]        last_w;
  logic [WORD_BITS-1:0] pmask;
  scan_res_t            scan;

  // Volume size and reserved area, clamped
  always_comb begin
    if (32'(blocks_q) > NUM_BLOCKS) tot = BA_W'(NUM_BLOCKS);
    else                            tot = BA_W'(blocks_q);
    ds   = (BA_W'(dstart_q) < tot) ? BA_W'(dstart_q) : tot;
    fend = BA_W'(req_i.first_block) + BA_W'(req_i.run_length);
  end

  assign last_w = XW'((hi_q - BA_W'(1)) >> 6);
  assign pmask  = range_mask(pw_q, lo_q, hi_q);

  bcba_map_ram #(.DEPTH(NUM_WORDS), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (w_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  bcba_word_scan u_scan (
    .free_i  (~ram_rdata & pmask),
    .base_i  (BA_W'({pw_q, 6'd0})),
    .carry_i (carry_q),
    .len_i   (len_q),
    .res_o   (scan)
  );

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = ostat_q;
  assign rsp_o.alloc_start = ostart_q;
  assign rsp_o.free_count  = ocnt_q;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    w_d      = w_q;
    pw_d     = pw_q;
    pv_d     = 1'b0;
    lo_d     = lo_q;
    hi_d     = hi_q;
    carry_d  = carry_q;
    set_d    = set_q;
    clr_d    = clr_q;
    len_d    = len_q;
    stat_d   = stat_q;
    start_d  = start_q;
    ov_d     = ov_q;
    ostat_d  = ostat_q;
    ostart_d = ostart_q;
    ocnt_d   = ocnt_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = pw_q[AW-1:0];
    ram_wdata = '0;

    // Drop the response once transferred
    if (ov_q && rsp_o.ready) ov_d = 1'b0;

    unique case (state_q)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = w_q[AW-1:0];
        ram_wdata = range_mask(w_q, '0, hi_q);
        w_d       = w_q + XW'(1);
        if (w_q == LAST_WORD) begin
          state_d = clr_q ? ST_IDLE : ST_DONE;
          clr_d   = 1'b0;
        end
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          len_d   = req_i.run_length;
          start_d = '0;
          stat_d  = STAT_BAD;
          state_d = ST_DONE;
          carry_d = '0;
          case (req_i.func)
            FUNC_FORMAT: begin
              hi_d    = ds;
              w_d     = '0;
              cnt_d   = 16'(tot - ds);
              stat_d  = STAT_OK;
              state_d = ST_SWEEP;
            end
            FUNC_FREE: begin
              if (req_i.run_length != 16'd0 && fend <= tot) begin
                lo_d    = BA_W'(req_i.first_block);
                hi_d    = fend;
                w_d     = XW'(BA_W'(req_i.first_block) >> 6);
                set_d   = 1'b0;
                stat_d  = STAT_OK;
                state_d = ST_RMW;
                if ({1'b0, cnt_q} + {1'b0, req_i.run_length} > {1'b0, CNT_MAX}) begin
                  cnt_d = CNT_MAX;
                end else begin
                  cnt_d = cnt_q + req_i.run_length;
                end
              end
            end
            FUNC_ALLOC: begin
              if (req_i.run_length != 16'd0 && BA_W'(req_i.run_length) <= tot) begin
                if (ds >= tot) begin
                  stat_d = STAT_NOSPACE;
                end else begin
                  lo_d    = ds;
                  hi_d    = tot;
                  w_d     = XW'(ds >> 6);
                  state_d = ST_SCAN;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // Stream reads, search the word that returned
        if (w_q <= last_w) begin
          ram_re = 1'b1;
          pw_d   = w_q;
          pv_d   = 1'b1;
          w_d    = w_q + XW'(1);
        end
        if (pv_q) begin
          carry_d = scan.carry;
          if (scan.hit) begin
            start_d = scan.start;
            lo_d    = scan.start;
            hi_d    = scan.start + BA_W'(len_q);
            w_d     = XW'(scan.start >> 6);
            pv_d    = 1'b0;
            ram_re  = 1'b0;
            set_d   = 1'b1;
            stat_d  = STAT_OK;
            cnt_d   = (cnt_q > len_q) ? cnt_q - len_q : '0;
            state_d = ST_RMW;
          end else if (pw_q == last_w) begin
            pv_d    = 1'b0;
            stat_d  = STAT_NOSPACE;
            state_d = ST_DONE;
          end
        end
      end

      ST_RMW: begin
        // Read the next word while the previous one is written back
        if (w_q <= last_w) begin
          ram_re = 1'b1;
          pw_d   = w_q;
          pv_d   = 1'b1;
          w_d    = w_q + XW'(1);
        end
        if (pv_q) begin
          ram_we    = 1'b1;
          ram_wdata = set_q ? (ram_rdata | pmask) : (ram_rdata & ~pmask);
          if (pw_q == last_w) begin
            pv_d    = 1'b0;
            ram_re  = 1'b0;
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d     = 1'b1;
          ostat_d  = stat_q;
          ostart_d = start_q[14:0];
          ocnt_d   = cnt_q;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SWEEP;
      clr_q    <= 1'b1;
      hi_q     <= '0;
      w_q      <= '0;
      pv_q     <= 1'b0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
      dstart_q <= DATA_START_RST;
      blocks_q <= BLOCKS_RST;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hi_q    <= hi_d;
      w_q     <= w_d;
      pv_q    <= pv_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DATA_START: dstart_q <= cfg_data_i;
          CFG_BLOCKS:     blocks_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pw_q     <= pw_d;
    lo_q     <= lo_d;
    carry_q  <= carry_d;
    set_q    <= set_d;
    len_q    <= len_d;
    stat_q   <= stat_d;
    start_q  <= start_d;
    ostat_q  <= ostat_d;
    ostart_q <= ostart_d;
    ocnt_q   <= ocnt_d;
  end

  // A read never targets the word written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != w_q[AW-1:0]))
    else $error("map read and write hit the same word");

  // Returned read data is only pending inside a walk
  a_pv_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (state_q == ST_SCAN || state_q == ST_RMW))
    else $error("read data pending outside a walk");

  // A new response is loaded only from the finishing state
  a_rsp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> ($past(state_q) == ST_DONE))
    else $error("response raised outside the finishing state");

  // No request is taken during the clearing pass
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !req_i.ready)
    else $error("request taken during map clear");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the bitmap contiguous block allocator.
// ----------------------------------------------------------------------------
// A shadow used map and free counter predict every response. Requests come
// in phases, one per volume/reserved-area setting, with directed requests
// first and random ones after. The request side sends in bursts with gaps,
// and the response side stalls on a pattern of its own, with one long hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import bcba_pkg::*; ();

  localparam int unsigned MAP_SIZE   = NUM_BLOCKS_DEF;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned SETTLE     = 1100;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] run_length;
    logic [14:0] first_block;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] alloc_start;
    logic [15:0] free_count;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  bcba_req_if req_ch ();
  bcba_rsp_if rsp_ch ();

  bitmap_contiguous_block_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch.sink),
    .rsp_o      (rsp_ch.source)
  );

  // Shadow state of the allocator
  bit          shadow_map [MAP_SIZE];
  int unsigned shadow_count;
  int unsigned shadow_data_start;
  int unsigned shadow_blocks;

  request_t    pending_reqs [$];
  answer_t     expected_answers [$];
  int unsigned error_count;
  int unsigned answers_seen;
  int unsigned idle_cycles;
  int unsigned sent_count;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned volume_size();
    return (shadow_blocks < MAP_SIZE) ? shadow_blocks : MAP_SIZE;
  endfunction

  // Compute the answer to one request and update the shadow state
  function automatic answer_t apply_request(request_t rq);
    answer_t     ans;
    int unsigned vol, rsv, len, first, run, hit_at;
    bit          found;
    vol    = volume_size();
    rsv    = (shadow_data_start < vol) ? shadow_data_start : vol;
    len    = rq.run_length;
    first  = rq.first_block;
    ans    = '0;
    ans.status = STAT_BAD;
    found  = 1'b0;
    run    = 0;
    hit_at = 0;
    case (rq.func)
      FUNC_FORMAT: begin
        for (int b = 0; b < MAP_SIZE; b++) shadow_map[b] = (b < rsv);
        shadow_count = vol - rsv;
        ans.status = STAT_OK;
      end
      FUNC_ALLOC: begin
        if (len != 0 && len <= vol) begin
          for (int b = rsv; b < vol && !found; b++) begin
            if (!shadow_map[b]) begin
              run++;
              if (run == len) begin
                found  = 1'b1;
                hit_at = b + 1 - len;
              end
            end else begin
              run = 0;
            end
          end
          if (found) begin
            for (int b = hit_at; b < hit_at + len; b++) shadow_map[b] = 1'b1;
            shadow_count = (shadow_count > len) ? shadow_count - len : 0;
            ans.status      = STAT_OK;
            ans.alloc_start = hit_at[14:0];
          end else begin
            ans.status = STAT_NOSPACE;
          end
        end
      end
      FUNC_FREE: begin
        if (len != 0 && first + len <= vol) begin
          for (int b = first; b < first + len; b++) shadow_map[b] = 1'b0;
          shadow_count = shadow_count + len;
          if (shadow_count > CNT_MAX) shadow_count = CNT_MAX;
          ans.status = STAT_OK;
        end
      end
      default: ;
    endcase
    ans.free_count = shadow_count[15:0];
    return ans;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d (answer %0d)", what, got, want,
             answers_seen);
    error_count++;
  endtask

  // Request driver: bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned offered_count;

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid       <= 1'b0;
      req_ch.func        <= FUNC_ALLOC;
      req_ch.run_length  <= '0;
      req_ch.first_block <= '0;
      burst_left         <= 0;
      gap_left           <= 0;
      offered_count      <= 0;
    end else if (req_ch.valid && sent_count != offered_count) begin
      // hold the offer until it is transferred
    end else if (gap_left != 0) begin
      req_ch.valid <= 1'b0;
      gap_left     <= gap_left - 1;
    end else if (pending_reqs.size() != 0) begin
      req_ch.valid       <= 1'b1;
      req_ch.func        <= pending_reqs[0].func;
      req_ch.run_length  <= pending_reqs[0].run_length;
      req_ch.first_block <= pending_reqs[0].first_block;
      offered_count      <= offered_count + 1;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 12);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Response stall pattern, with one long hold
  int unsigned stall_mode;
  int unsigned mode_timer;
  int unsigned hold_left;
  bit          hold_done;

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_mode   <= 0;
      mode_timer   <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      mode_timer <= mode_timer + 1;
      if (mode_timer == 300) begin
        mode_timer <= 0;
        stall_mode <= $urandom_range(0, 3);
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && answers_seen == 200) begin
        hold_done    <= 1'b1;
        hold_left    <= 3000;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= $urandom_range(0, 1);
          2: rsp_ch.ready <= (mode_timer[1:0] == 2'd0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor: predict on request transfer, check on response transfer
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (req_ch.valid && req_ch.ready) begin
        expected_answers.push_back(apply_request(pending_reqs.pop_front()));
        idle_cycles <= 0;
        sent_count  <= sent_count + 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        idle_cycles <= 0;
        answers_seen++;
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected answer status", rsp_ch.status, 0);
        end else begin
          want = expected_answers.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", rsp_ch.status, want.status);
          if (rsp_ch.alloc_start !== want.alloc_start)
            report_mismatch("alloc_start", rsp_ch.alloc_start, want.alloc_start);
          if (rsp_ch.free_count !== want.free_count)
            report_mismatch("free_count", rsp_ch.free_count, want.free_count);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if (rst_ni && idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_register(logic idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[15:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_DATA_START) shadow_data_start = value & 16'hFFFF;
    else shadow_blocks = value & 16'hFFFF;
  endtask

  task automatic queue_request(logic [1:0] func, int unsigned len, int unsigned first);
    request_t rq;
    rq.func        = func;
    rq.run_length  = len[15:0];
    rq.first_block = first[14:0];
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_answers.size() != 0 || req_ch.valid)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One random request, mostly sized to the current volume
  task automatic queue_random_request();
    int unsigned vol, pick, len, first;
    logic [1:0]  func;
    vol  = volume_size();
    pick = $urandom_range(0, 99);
    if (pick < 48) func = FUNC_ALLOC;
    else if (pick < 88) func = FUNC_FREE;
    else if (pick < 94) func = FUNC_FORMAT;
    else func = 2'd3;
    pick = $urandom_range(0, 9);
    if (pick < 7) len = $urandom_range(1, (vol / 6 > 1) ? vol / 6 : 1);
    else if (pick == 7) len = 0;
    else if (pick == 8) len = $urandom_range(0, 65535);
    else len = $urandom_range(1, (vol > 1) ? vol : 1);
    if ($urandom_range(0, 9) < 7) first = $urandom_range(0, (vol > 1) ? vol - 1 : 0);
    else first = $urandom_range(0, 32767);
    queue_request(func, len, first);
  endtask

  int unsigned phase_ds [9] = '{0, 63, 0, 0, 32768, 65535, 10, 500, 138};
  int unsigned phase_vb [9] = '{64, 64, 1, 0, 100, 65535, 300, 2000, 32768};

  // Stimulus
  initial begin
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_DATA_START;
    cfg_data_i         = '0;
    error_count        = 0;
    answers_seen       = 0;
    idle_cycles        = 0;
    sent_count         = 0;
    shadow_count       = 0;
    shadow_data_start  = DATA_START_RST;
    shadow_blocks      = BLOCKS_RST;
    foreach (shadow_map[b]) shadow_map[b] = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings, allocate before format, edges and saturation
    queue_request(FUNC_ALLOC, 1, 0);
    queue_request(FUNC_FORMAT, 0, 0);
    queue_request(FUNC_ALLOC, 0, 0);
    queue_request(FUNC_ALLOC, 32768, 0);
    queue_request(FUNC_ALLOC, 65535, 32767);
    queue_request(FUNC_FREE, 0, 0);
    queue_request(FUNC_FREE, 1, 32767);
    queue_request(FUNC_FREE, 2, 32767);
    queue_request(2'd3, 5, 5);
    queue_request(FUNC_ALLOC, 1, 0);
    queue_request(FUNC_ALLOC, 100, 0);
    queue_request(FUNC_FREE, 50, 138);
    queue_request(FUNC_ALLOC, 30, 0);
    queue_request(FUNC_FREE, 65535, 0);
    queue_request(FUNC_FREE, 32768, 0);
    queue_request(FUNC_FREE, 32768, 0);
    queue_request(FUNC_ALLOC, 32630, 0);
    queue_request(FUNC_ALLOC, 1, 0);
    queue_request(FUNC_FORMAT, 0, 0);
    queue_request(FUNC_ALLOC, 32630, 0);
    wait_drained();

    // Random phases across register settings
    foreach (phase_ds[p]) begin
      write_register(CFG_DATA_START, phase_ds[p]);
      write_register(CFG_BLOCKS, phase_vb[p]);
      queue_request(FUNC_FORMAT, 0, 0);
      for (int n = 0; n < 128; n++) queue_random_request();
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/bcba_pkg.sv
hw/rtl/bcba_if.sv
hw/rtl/bcba_map_ram.sv
hw/rtl/bcba_word_scan.sv
hw/rtl/bitmap_contiguous_block_allocator.sv
tb/sv/tb_top.sv
